// ===== sv/ffha_pkg.sv =====
// Package for the first-fit hole allocator.
// Holds command codes, controller states, channel beat structs and command/status structs.
`default_nettype none
package ffha_pkg;
	localparam int unsigned MaxHolesDefault = 16;
	localparam int unsigned AddrBitsDefault = 16;

	typedef enum logic [1:0] {
		CMD_FREE    = 2'd0,
		CMD_RESERVE = 2'd1,
		CMD_FIT     = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic [AddrBitsDefault-1:0] from_address;
		logic [AddrBitsDefault-1:0] to_address;
		logic [AddrBitsDefault-1:0] block_size;
	} alloc_req_t;

	typedef struct packed {
		logic success;
		logic [AddrBitsDefault-1:0] block_start;
		logic [AddrBitsDefault-1:0] block_end;
		logic [AddrBitsDefault-1:0] free_total;
		logic [$clog2(MaxHolesDefault + 1)-1:0] hole_count;
		logic table_full;
	} alloc_rsp_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_SHIFT = 6'b001000,
		ST_MERGE = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_step;
		logic read_step;
		logic shift_step;
		logic merge_step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic shift_done;
		logic merge_done;
		logic need_shift;
		logic need_merge;
	} dp_status_t;
endpackage
`default_nettype wire

// ===== sv/ffha_if.sv =====
// Valid/ready channel interface carrying one payload beat.
// Depends on nothing.
`default_nettype none
interface ffha_if #(parameter type payload_t = logic) (input wire logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/ffha_ctrl.sv =====
// Controller state machine of the hole allocator.
// Depends on ffha_pkg.
`default_nettype none
module ffha_ctrl
	import ffha_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);
	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.read_step = 1'b1;
				if (status.need_shift) begin
					state_d = ST_SHIFT;
				end else if (status.need_merge) begin
					state_d = ST_MERGE;
				end else begin
					cmd.finish = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (status.shift_done) begin
					if (status.need_merge) begin
						state_d = ST_MERGE;
					end else begin
						cmd.finish = 1'b1;
						state_d = ST_OUT;
					end
				end
			end
			ST_MERGE: begin
				cmd.merge_step = 1'b1;
				if (status.merge_done) begin
					cmd.finish = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ===== sv/ffha_dp.sv =====
// Datapath of the hole allocator: hole table, scan, shift and merge.
// Depends on ffha_pkg.
`default_nettype none
module ffha_dp
	import ffha_pkg::*;
#(
	parameter int unsigned MAX_HOLES = MaxHolesDefault,
	parameter int unsigned ADDR_BITS = AddrBitsDefault,
	localparam int unsigned IW = $clog2(MAX_HOLES),
	localparam int unsigned CW = $clog2(MAX_HOLES + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_cmd_t              cmd,
	output dp_status_t                status,
	input  wire logic [1:0]           in_cmd,
	input  wire logic [ADDR_BITS-1:0] in_from,
	input  wire logic [ADDR_BITS-1:0] in_to,
	input  wire logic [ADDR_BITS-1:0] in_size,
	output logic                      o_success,
	output logic [ADDR_BITS-1:0]      o_bstart,
	output logic [ADDR_BITS-1:0]      o_bend,
	output logic [ADDR_BITS-1:0]      o_total,
	output logic [CW-1:0]             o_count,
	output logic                      o_full
);
	// Merge phases: 0 load the new hole, 1 check above, 2 drop above or check below, 3 drop below.
	logic [ADDR_BITS-1:0] hs_q [MAX_HOLES];
	logic [ADDR_BITS-1:0] he_q [MAX_HOLES];
	logic [CW-1:0] held_q;
	logic [ADDR_BITS-1:0] sum_q;
	logic [1:0] op_q;
	logic [ADDR_BITS-1:0] from_q, to_q, size_q;
	logic [CW-1:0] idx_q, pos_q;
	logic found_q, ok_q, full_q;
	logic [ADDR_BITS-1:0] bs_q, be_q;
	logic [1:0] mph_q;
	logic drop_act_q;
	logic [ADDR_BITS-1:0] rs_q, re_q;

	logic [IW-1:0] idx_i;
	logic scan_end;
	logic [ADDR_BITS-1:0] cur_s, cur_e, hsz;
	logic fits, stop_free;

	assign idx_i = idx_q[IW-1:0];
	assign scan_end = (idx_q >= held_q);
	assign cur_s = hs_q[idx_i];
	assign cur_e = he_q[idx_i];
	assign hsz = (cur_e > cur_s) ? cur_e - cur_s : '0;
	assign fits = hsz >= size_q;
	assign stop_free = (cur_s < from_q);

	logic is_free, free_ok;
	assign is_free = (cmd_t'(op_q) == CMD_FREE);
	assign free_ok = (held_q < CW'(MAX_HOLES)) && (to_q > from_q);

	always_comb begin
		status = '0;
		case (cmd_t'(op_q))
			CMD_FREE:    status.scan_done = !free_ok || scan_end || stop_free;
			CMD_RESERVE,
			CMD_FIT:     status.scan_done = scan_end || fits;
			default:     status.scan_done = 1'b1;
		endcase
		status.need_shift = (cmd_t'(op_q) == CMD_RESERVE) && found_q
			&& (cur_e - size_q <= cur_s);
		status.need_merge = is_free && ok_q;
		status.shift_done = (idx_q + 1'b1 >= held_q);
		status.merge_done = (mph_q == 2'd3) && !(drop_act_q && (idx_q + 1'b1 < held_q));
	end

	logic [ADDR_BITS:0] sum_add;
	assign sum_add = {1'b0, sum_q} + {1'b0, to_q - from_q};

	// Hole count decrements during merge drops.
	logic merge_drop_end;
	assign merge_drop_end = cmd.merge_step && drop_act_q && !(idx_q + 1'b1 < held_q)
		&& (mph_q == 2'd2 || mph_q == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			sum_q <= '0;
		end else if (cmd.read_step) begin
			if (is_free && ok_q) begin
				held_q <= held_q + 1'b1;
				sum_q <= sum_add[ADDR_BITS] ? '1 : sum_add[ADDR_BITS-1:0];
			end else if (cmd_t'(op_q) == CMD_RESERVE && found_q) begin
				sum_q <= (sum_q >= size_q) ? sum_q - size_q : '0;
			end
		end else if (cmd.shift_step && status.shift_done && drop_act_q) begin
			held_q <= held_q - 1'b1;
		end else if (merge_drop_end) begin
			held_q <= held_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_cmd;
			from_q <= in_from;
			to_q <= in_to;
			size_q <= in_size;
			idx_q <= '0;
			found_q <= 1'b0;
			ok_q <= 1'b0;
			full_q <= 1'b0;
			bs_q <= '0;
			be_q <= '0;
			drop_act_q <= 1'b0;
			mph_q <= '0;
		end else if (cmd.scan_step) begin
			if (status.scan_done) begin
				pos_q <= idx_q;
				if (is_free) begin
					full_q <= !(held_q < CW'(MAX_HOLES));
					ok_q <= free_ok;
				end else begin
					found_q <= !scan_end && (cmd_t'(op_q) != CMD_NONE);
				end
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end else if (cmd.read_step) begin
			if (is_free && ok_q) begin
				// Insert at pos by shifting entries up; done in one step as a
				// register file rotate over independent entries.
				for (int k = MAX_HOLES - 1; k > 0; k--) begin
					if (CW'(k) > pos_q && CW'(k) <= held_q) begin
						hs_q[k] <= hs_q[k-1];
						he_q[k] <= he_q[k-1];
					end
				end
				hs_q[pos_q[IW-1:0]] <= from_q;
				he_q[pos_q[IW-1:0]] <= to_q;
			end else if (cmd_t'(op_q) == CMD_RESERVE && found_q) begin
				ok_q <= 1'b1;
				be_q <= cur_e;
				bs_q <= cur_e - size_q;
				he_q[idx_i] <= cur_e - size_q;
				if (cur_e - size_q <= cur_s) begin
					drop_act_q <= 1'b1;
				end
			end else if (cmd_t'(op_q) == CMD_FIT) begin
				ok_q <= found_q;
			end
		end else if (cmd.shift_step) begin
			if (idx_q + 1'b1 < held_q) begin
				hs_q[idx_i] <= hs_q[idx_i + 1'b1];
				he_q[idx_i] <= he_q[idx_i + 1'b1];
				idx_q <= idx_q + 1'b1;
			end else begin
				drop_act_q <= 1'b0;
				idx_q <= pos_q;
				mph_q <= '0;
			end
		end else if (cmd.merge_step) begin
			case (mph_q)
				2'd0: begin
					rs_q <= hs_q[pos_q[IW-1:0]];
					re_q <= he_q[pos_q[IW-1:0]];
					mph_q <= 2'd1;
				end
				2'd1: begin
					if (pos_q != '0 && hs_q[pos_q[IW-1:0] - 1'b1] == re_q) begin
						hs_q[pos_q[IW-1:0] - 1'b1] <= rs_q;
						re_q <= he_q[pos_q[IW-1:0] - 1'b1];
						idx_q <= pos_q;
						pos_q <= pos_q - 1'b1;
						drop_act_q <= 1'b1;
					end
					mph_q <= 2'd2;
				end
				2'd2: begin
					if (drop_act_q) begin
						if (idx_q + 1'b1 < held_q) begin
							hs_q[idx_i] <= hs_q[idx_i + 1'b1];
							he_q[idx_i] <= he_q[idx_i + 1'b1];
							idx_q <= idx_q + 1'b1;
						end else begin
							drop_act_q <= 1'b0;
						end
					end else if (pos_q + 1'b1 < held_q
							&& he_q[pos_q[IW-1:0] + 1'b1] == rs_q) begin
						he_q[pos_q[IW-1:0] + 1'b1] <= re_q;
						idx_q <= pos_q;
						drop_act_q <= 1'b1;
						mph_q <= 2'd3;
					end else begin
						mph_q <= 2'd3;
					end
				end
				default: begin
					if (drop_act_q) begin
						if (idx_q + 1'b1 < held_q) begin
							hs_q[idx_i] <= hs_q[idx_i + 1'b1];
							he_q[idx_i] <= he_q[idx_i + 1'b1];
							idx_q <= idx_q + 1'b1;
						end else begin
							drop_act_q <= 1'b0;
						end
					end
				end
			endcase
		end
	end

	assign o_success = ok_q;
	assign o_bstart = bs_q;
	assign o_bend = be_q;
	assign o_total = sum_q;
	assign o_count = held_q;
	assign o_full = full_q;
endmodule
`default_nettype wire

// ===== sv/first_fit_hole_allocator_unit.sv =====
// First-fit hole allocator: free with coalescing, reserve, fit query.
// The table scan and the drops after a used-up reserve or a merge each step through
// one entry per cycle; one command at a time: a new command is taken only in idle,
// after the previous result beat has been accepted.
// Reset: arst_n clears hole count and free total; table contents undefined.
`default_nettype none
module first_fit_hole_allocator_unit
	import ffha_pkg::*;
#(
	parameter int unsigned MAX_HOLES = MaxHolesDefault,
	parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	ffha_if.sink     in_ch,
	ffha_if.source   out_ch
);
	dp_cmd_t dcmd;
	dp_status_t dstat;
	logic ir, ov;

	ffha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(ir),
		.out_valid(ov), .out_ready(out_ch.ready),
		.status(dstat), .cmd(dcmd)
	);

	logic [4:0] cnt_w;
	logic [$clog2(MAX_HOLES+1)-1:0] cnt;

	ffha_dp #(.MAX_HOLES(MAX_HOLES), .ADDR_BITS(ADDR_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(dcmd), .status(dstat),
		.in_cmd(in_ch.data.cmd),
		.in_from(in_ch.data.from_address),
		.in_to(in_ch.data.to_address),
		.in_size(in_ch.data.block_size),
		.o_success(out_ch.data.success),
		.o_bstart(out_ch.data.block_start),
		.o_bend(out_ch.data.block_end),
		.o_total(out_ch.data.free_total),
		.o_count(cnt),
		.o_full(out_ch.data.table_full)
	);

	assign cnt_w = 5'(cnt);
	assign out_ch.data.hole_count = cnt_w;
	assign in_ch.ready = ir;
	assign out_ch.valid = ov;
endmodule
`default_nettype wire

// ===== tb/sv/first_fit_hole_allocator_unit_tb.sv =====
// Testbench for first_fit_hole_allocator_unit: directed and random commands.
// Each result is checked against a predictor of the hole table.
// Depends on ffha_pkg, ffha_if and the allocator RTL.
`timescale 1ns / 1ps
module first_fit_hole_allocator_unit_tb;
	import ffha_pkg::*;

	class hole_table_scoreboard;
		logic [15:0] lo[17];
		logic [15:0] hi[17];
		int held;
		int total;
		int errors;
		alloc_rsp_t pending[$];

		function new();
			held = 0;
			total = 0;
			errors = 0;
		endfunction

		function void drop(int i);
			for (int k = i; k + 1 < held; k++) begin
				lo[k] = lo[k + 1];
				hi[k] = hi[k + 1];
			end
			held--;
		endfunction

		function int first_fit(int size);
			for (int i = 0; i < held; i++) begin
				if (int'(hi[i]) - int'(lo[i]) >= size)
					return i;
			end
			return -1;
		endfunction

		function void note_request(alloc_req_t r);
			alloc_rsp_t e;
			int pos;
			int w;
			int sz;
			e = '0;
			sz = r.block_size;
			case (r.cmd)
				CMD_FREE: begin
					if (held >= 16) begin
						e.table_full = 1'b1;
					end else if (r.to_address > r.from_address) begin
						pos = 0;
						while (pos < held && lo[pos] >= r.from_address)
							pos++;
						for (int k = held; k > pos; k--) begin
							lo[k] = lo[k - 1];
							hi[k] = hi[k - 1];
						end
						lo[pos] = r.from_address;
						hi[pos] = r.to_address;
						held++;
						total += int'(r.to_address) - int'(r.from_address);
						if (total > 65535)
							total = 65535;
						if (pos > 0 && lo[pos - 1] == hi[pos]) begin
							lo[pos - 1] = lo[pos];
							drop(pos);
							pos--;
						end
						if (pos + 1 < held && hi[pos + 1] == lo[pos]) begin
							hi[pos + 1] = hi[pos];
							drop(pos);
						end
						e.success = 1'b1;
					end
				end
				CMD_RESERVE: begin
					w = first_fit(sz);
					if (w >= 0) begin
						e.block_end = hi[w];
						hi[w] = hi[w] - 16'(sz);
						e.block_start = hi[w];
						if (hi[w] <= lo[w])
							drop(w);
						total = (total >= sz) ? total - sz : 0;
						e.success = 1'b1;
					end
				end
				CMD_FIT: e.success = (first_fit(sz) >= 0);
				default: ;
			endcase
			e.free_total = 16'(total);
			e.hole_count = 5'(held);
			pending.push_back(e);
		endfunction

		function void check_result(alloc_rsp_t a);
			alloc_rsp_t e;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.success !== e.success) begin
				$error("success: expected %0d, got %0d", e.success, a.success);
				errors++;
			end
			if (a.block_start !== e.block_start) begin
				$error("block_start: expected %0d, got %0d", e.block_start, a.block_start);
				errors++;
			end
			if (a.block_end !== e.block_end) begin
				$error("block_end: expected %0d, got %0d", e.block_end, a.block_end);
				errors++;
			end
			if (a.free_total !== e.free_total) begin
				$error("free_total: expected %0d, got %0d", e.free_total, a.free_total);
				errors++;
			end
			if (a.hole_count !== e.hole_count) begin
				$error("hole_count: expected %0d, got %0d", e.hole_count, a.hole_count);
				errors++;
			end
			if (a.table_full !== e.table_full) begin
				$error("table_full: expected %0d, got %0d", e.table_full, a.table_full);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int cycles = 0;
	bit calm = 0;
	hole_table_scoreboard sb = new();

	ffha_if #(.payload_t(alloc_req_t)) in_ch (.clk(clk));
	ffha_if #(.payload_t(alloc_rsp_t)) out_ch (.clk(clk));

	first_fit_hole_allocator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always #5 clk = ~clk;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always begin
		@(posedge clk);
		if (arst_n)
			out_ch.ready <= calm || ($urandom_range(99) >= 37);
		@(negedge clk);
		if (out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.data);
	end

	task automatic send_request(cmd_t c, int from, int to, int size);
		alloc_req_t r;
		r.cmd = c;
		r.from_address = 16'(from);
		r.to_address = 16'(to);
		r.block_size = 16'(size);
		while (!calm && $urandom_range(99) < 37) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= r;
		do begin
			@(negedge clk);
		end while (!in_ch.ready);
		@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic send_random(ref int last_lo, ref int last_hi);
		int p;
		int from;
		int len;
		p = $urandom_range(99);
		if (p < 45) begin
			len = ($urandom_range(19) == 0) ? $urandom_range(65535, 1) : $urandom_range(400, 1);
			case ($urandom_range(3))
				0: from = last_hi;
				1: from = last_lo - len;
				default: from = $urandom_range(65535);
			endcase
			if (from < 0)
				from = 0;
			if (from + len > 65535)
				len = 65535 - from;
			send_request(CMD_FREE, from, from + len, $urandom_range(65535));
			last_lo = from;
			last_hi = from + len;
		end else if (p < 78) begin
			send_request(CMD_RESERVE, $urandom_range(65535), $urandom_range(65535),
				($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(500));
		end else if (p < 92) begin
			send_request(CMD_FIT, $urandom_range(65535), $urandom_range(65535),
				($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(800));
		end else if (p < 97) begin
			from = $urandom_range(65535);
			send_request(CMD_FREE, from, $urandom_range(from), $urandom_range(65535));
		end else begin
			send_request(CMD_NONE, $urandom_range(65535), $urandom_range(65535),
				$urandom_range(65535));
		end
	endtask

	initial begin
		int last_lo;
		int last_hi;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(CMD_RESERVE, 0, 0, 0);
		send_request(CMD_FIT, 0, 0, 0);
		send_request(CMD_FREE, 100, 100, 0);
		send_request(CMD_FREE, 65535, 0, 65535);
		send_request(CMD_FREE, 0, 65535, 0);
		send_request(CMD_FIT, 0, 0, 65535);
		send_request(CMD_FIT, 0, 0, 65535);
		send_request(CMD_RESERVE, 0, 0, 0);
		send_request(CMD_RESERVE, 0, 0, 65535);
		send_request(CMD_FREE, 1000, 2000, 0);
		send_request(CMD_FREE, 3000, 4000, 0);
		send_request(CMD_FREE, 2000, 3000, 0);
		send_request(CMD_FREE, 3000, 3500, 0);
		send_request(CMD_FREE, 0, 65535, 0);
		send_request(CMD_FIT, 0, 0, 1001);
		send_request(CMD_RESERVE, 0, 0, 1001);
		send_request(CMD_RESERVE, 0, 0, 3000);
		send_request(CMD_NONE, 65535, 65535, 65535);
		for (int i = 0; i < 17; i++)
			send_request(CMD_FREE, 10000 + 100 * i, 10010 + 100 * i, 0);
		send_request(CMD_FREE, 5000, 5001, 0);
		send_request(CMD_RESERVE, 0, 0, 10);

		last_lo = 20000;
		last_hi = 20000;
		for (int n = 0; n < 850; n++) begin
			calm = (n >= 350 && n < 500);
			send_random(last_lo, last_hi);
		end
		calm = 0;
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/ffha_pkg.sv
sv/ffha_if.sv
sv/ffha_ctrl.sv
sv/ffha_dp.sv
sv/first_fit_hole_allocator_unit.sv
tb/sv/first_fit_hole_allocator_unit_tb.sv
